// ----- rtl/mwalu_pkg.sv -----
package mwalu_pkg;

    // default operand width in bytes
    localparam int DEF_WIDTH_BYTES = 4;

    // operation codes carried on the input tuser
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_NEG = 3'd1;
    localparam logic [2:0] OP_CMP = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;

    // compare outcome codes
    localparam logic [1:0] ORD_EQ = 2'd0;
    localparam logic [1:0] ORD_LT = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    // microprogram addresses
    typedef logic [2:0] upc_t;
    localparam upc_t A_FETCH = 3'd0;
    localparam upc_t A_ADD   = 3'd1;
    localparam upc_t A_NEG   = 3'd2;
    localparam upc_t A_CMP   = 3'd3;
    localparam upc_t A_MUL   = 3'd4;
    localparam upc_t A_DIV   = 3'd5;
    localparam upc_t A_EMIT  = 3'd6;
    localparam upc_t A_SPARE = 3'd7;

    // datapath operation of one microstep
    typedef enum logic [2:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_ADD,
        UOP_NEG,
        UOP_CMP,
        UOP_MUL,
        UOP_DIV,
        UOP_EMIT
    } uop_t;

    // sequencing of one microstep
    typedef enum logic [1:0] {
        BR_DISPATCH,
        BR_JUMP,
        BR_LOOP,
        BR_EMIT
    } br_t;

    typedef struct packed {
        uop_t uop;
        br_t  br;
        upc_t target;
    } ctrl_t;

    // microprogram rom
    function automatic ctrl_t urom(input upc_t addr);
        ctrl_t w;
        unique case (addr)
            A_FETCH: w = '{uop: UOP_LOAD, br: BR_DISPATCH, target: A_FETCH};
            A_ADD:   w = '{uop: UOP_ADD,  br: BR_JUMP,     target: A_EMIT};
            A_NEG:   w = '{uop: UOP_NEG,  br: BR_JUMP,     target: A_EMIT};
            A_CMP:   w = '{uop: UOP_CMP,  br: BR_JUMP,     target: A_EMIT};
            A_MUL:   w = '{uop: UOP_MUL,  br: BR_LOOP,     target: A_EMIT};
            A_DIV:   w = '{uop: UOP_DIV,  br: BR_LOOP,     target: A_EMIT};
            A_EMIT:  w = '{uop: UOP_EMIT, br: BR_EMIT,     target: A_FETCH};
            A_SPARE: w = '{uop: UOP_NONE, br: BR_JUMP,     target: A_FETCH};
        endcase
        return w;
    endfunction

    // entry point of each operation; unknown codes go straight to the result
    function automatic upc_t dispatch(input logic [2:0] op);
        upc_t a;
        unique case (op)
            OP_ADD:  a = A_ADD;
            OP_NEG:  a = A_NEG;
            OP_CMP:  a = A_CMP;
            OP_MUL:  a = A_MUL;
            OP_DIV:  a = A_DIV;
            default: a = A_EMIT;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/multiword_integer_alu_unit.sv -----
// Integer arithmetic unit on WIDTH_BYTES*8-bit unsigned numbers: add, negate A, unsigned
// compare, low product (MSB-first shift-and-add) and restoring division with quotient and
// remainder (divide by zero gives an all-ones quotient and the numerator as remainder).
// Operands enter on 32-bit fields and are cut or zero-extended to the working width; the
// result fields are 32 bits wide and is_negative is the top bit of the working result.
// One item is worked on at a time under a small microprogram. Add, negate and compare
// pass through fetch, one work step and the result step; unknown op codes skip the work
// step. Multiply and divide run one shift-add or compare-subtract step per operand bit
// in a single shared datapath between fetch and the result step.
// The finished item sits in an output register, so the next item can be accepted while it
// waits to be taken; if that register is still full when the next result is ready, the
// unit waits at its result step until the held item is taken.
module multiword_integer_alu_unit
    import mwalu_pkg::*;
#(
    parameter int WIDTH_BYTES = DEF_WIDTH_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [2:0]  s_axis_tuser,   // op [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // main_result [31:0], remainder [63:32], order [65:64]
    output logic [0:0]  m_axis_tuser    // is_negative [0]
);

    localparam int NUM_BITS = WIDTH_BYTES * 8;
    localparam int EXT_W    = (NUM_BITS > 32) ? NUM_BITS : 32;
    localparam int CNT_W    = $clog2(NUM_BITS);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_BITS - 1);

    // sequencer state
    upc_t             upc_reg, upc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    ctrl_t            ctrl;

    // datapath registers
    logic [NUM_BITS-1:0] a_reg, a_next;
    logic [NUM_BITS-1:0] b_reg, b_next;
    logic [NUM_BITS-1:0] acc_reg, acc_next;
    logic [NUM_BITS-1:0] rem_reg, rem_next;
    logic [1:0]          ord_reg, ord_next;

    // output register
    logic        out_valid_reg;
    logic [31:0] out_main_reg;
    logic [31:0] out_rem_reg;
    logic [1:0]  out_ord_reg;
    logic        out_neg_reg;

    logic                in_acc;
    logic                out_free;
    logic                emit;
    logic [EXT_W-1:0]    a_in_ext, b_in_ext, acc_ext, rem_ext;
    logic [NUM_BITS-1:0] a_in, b_in;
    logic [NUM_BITS-1:0] mul_add;
    logic [NUM_BITS-1:0] rem_sh;
    logic                div_take;

    assign ctrl = urom(upc_reg);

    // input fields to working width
    assign a_in_ext = EXT_W'(s_axis_tdata[31:0]);
    assign b_in_ext = EXT_W'(s_axis_tdata[63:32]);
    assign a_in     = a_in_ext[NUM_BITS-1:0];
    assign b_in     = b_in_ext[NUM_BITS-1:0];

    assign s_axis_tready = (upc_reg == A_FETCH);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign emit          = (ctrl.uop == UOP_EMIT) && out_free;

    // step counter and next microprogram address
    always_comb begin
        upc_next = upc_reg;
        cnt_next = cnt_reg;
        unique case (ctrl.br)
            BR_DISPATCH: begin
                if (in_acc) begin
                    upc_next = dispatch(s_axis_tuser);
                    cnt_next = CNT_LAST;
                end
            end
            BR_JUMP: upc_next = ctrl.target;
            BR_LOOP: begin
                if (cnt_reg == '0) begin
                    upc_next = ctrl.target;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            BR_EMIT: begin
                if (out_free) begin
                    upc_next = ctrl.target;
                end
            end
        endcase
    end

    // shift-add and compare-subtract steps
    assign mul_add  = {acc_reg[NUM_BITS-2:0], 1'b0} + (b_reg[NUM_BITS-1] ? a_reg : '0);
    assign rem_sh   = {rem_reg[NUM_BITS-2:0], a_reg[NUM_BITS-1]};
    assign div_take = rem_reg[NUM_BITS-1] || (rem_sh >= b_reg);

    // datapath next values
    always_comb begin
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        ord_next = ord_reg;
        unique case (ctrl.uop)
            UOP_LOAD: begin
                if (in_acc) begin
                    a_next   = a_in;
                    b_next   = b_in;
                    acc_next = '0;
                    rem_next = '0;
                    ord_next = ORD_EQ;
                end
            end
            UOP_ADD: acc_next = a_reg + b_reg;
            UOP_NEG: acc_next = '0 - a_reg;
            UOP_CMP: begin
                if (a_reg == b_reg) begin
                    ord_next = ORD_EQ;
                end else if (a_reg < b_reg) begin
                    ord_next = ORD_LT;
                end else begin
                    ord_next = ORD_GT;
                end
            end
            UOP_MUL: begin
                acc_next = mul_add;
                b_next   = {b_reg[NUM_BITS-2:0], 1'b0};
            end
            UOP_DIV: begin
                a_next   = {a_reg[NUM_BITS-2:0], 1'b0};
                acc_next = {acc_reg[NUM_BITS-2:0], div_take};
                rem_next = div_take ? (rem_sh - b_reg) : rem_sh;
            end
            UOP_NONE, UOP_EMIT: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= A_FETCH;
            cnt_reg <= '0;
        end else begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        ord_reg <= ord_next;
    end

    // result fields to port width
    assign acc_ext = EXT_W'(acc_reg);
    assign rem_ext = EXT_W'(rem_reg);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_main_reg <= acc_ext[31:0];
            out_rem_reg  <= rem_ext[31:0];
            out_ord_reg  <= ord_reg;
            out_neg_reg  <= acc_reg[NUM_BITS-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_ord_reg, out_rem_reg, out_main_reg};
    assign m_axis_tuser  = out_neg_reg;

endmodule

// ----- bench/tb_multiword_integer_alu_unit.sv -----
`timescale 1ns / 100ps

module tb_multiword_integer_alu_unit
    import mwalu_pkg::*;
;

    // op codes that the unit does not know and answers with an all-zero result
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1300;
    localparam int MAX_REPORTS  = 10;

    // one input item and one result item
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] main_result;
        logic [31:0] remainder;
        logic [1:0]  order;
        logic        is_negative;
    } alu_res_t;

    // directed row: the result is typed in only where typed is set
    typedef struct packed {
        alu_req_t req;
        logic     typed;
        alu_res_t res;
    } dir_row_t;

    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{'{OP_ADD, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'h0000_0000, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_ADD, 32'hffff_ffff, 32'hffff_ffff}, 1'b1, '{32'hffff_fffe, 32'h0, ORD_EQ, 1'b1}},
        '{'{OP_ADD, 32'hffff_ffff, 32'h0000_0001}, 1'b1, '{32'h0000_0000, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_ADD, 32'h7fff_ffff, 32'h0000_0001}, 1'b1, '{32'h8000_0000, 32'h0, ORD_EQ, 1'b1}},
        '{'{OP_NEG, 32'h0000_0000, 32'hffff_ffff}, 1'b1, '{32'h0000_0000, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_NEG, 32'h0000_0001, 32'h0000_0000}, 1'b1, '{32'hffff_ffff, 32'h0, ORD_EQ, 1'b1}},
        '{'{OP_NEG, 32'h8000_0000, 32'h0000_0000}, 1'b1, '{32'h8000_0000, 32'h0, ORD_EQ, 1'b1}},
        '{'{OP_NEG, 32'hffff_ffff, 32'h1234_5678}, 1'b1, '{32'h0000_0001, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_CMP, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'h0000_0000, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_CMP, 32'h0000_0000, 32'hffff_ffff}, 1'b1, '{32'h0000_0000, 32'h0, ORD_LT, 1'b0}},
        '{'{OP_CMP, 32'hffff_ffff, 32'h0000_0000}, 1'b1, '{32'h0000_0000, 32'h0, ORD_GT, 1'b0}},
        '{'{OP_CMP, 32'hffff_ffff, 32'hffff_ffff}, 1'b1, '{32'h0000_0000, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_MUL, 32'hffff_ffff, 32'hffff_ffff}, 1'b1, '{32'h0000_0001, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_MUL, 32'h0000_0000, 32'hffff_ffff}, 1'b1, '{32'h0000_0000, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_MUL, 32'h0001_0000, 32'h0001_0000}, 1'b1, '{32'h0000_0000, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_MUL, 32'h1234_5678, 32'h9abc_def1}, 1'b0, '0},
        '{'{OP_DIV, 32'h1234_5678, 32'h0000_0000}, 1'b1,
          '{32'hffff_ffff, 32'h1234_5678, ORD_EQ, 1'b1}},
        '{'{OP_DIV, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'hffff_ffff, 32'h0, ORD_EQ, 1'b1}},
        '{'{OP_DIV, 32'hffff_ffff, 32'hffff_ffff}, 1'b1, '{32'h0000_0001, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_DIV, 32'hffff_ffff, 32'h8000_0001}, 1'b1,
          '{32'h0000_0001, 32'h7fff_fffe, ORD_EQ, 1'b0}},
        '{'{OP_DIV, 32'hffff_ffff, 32'h0000_0001}, 1'b1, '{32'hffff_ffff, 32'h0, ORD_EQ, 1'b1}},
        '{'{OP_DIV, 32'h0000_0000, 32'hffff_ffff}, 1'b1, '{32'h0000_0000, 32'h0, ORD_EQ, 1'b0}},
        '{'{OP_DIV, 32'h9abc_def0, 32'h0000_1234}, 1'b0, '0},
        '{'{OP_RSVD_5, 32'hffff_ffff, 32'hffff_ffff}, 1'b1, '0},
        '{'{OP_RSVD_6, 32'ha5a5_a5a5, 32'h5a5a_5a5a}, 1'b1, '0},
        '{'{OP_RSVD_7, 32'hffff_ffff, 32'h0000_0000}, 1'b1, '0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // operand_a [31:0], operand_b [63:32]
    logic [2:0]  s_axis_tuser = '0;   // op [2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // main_result [31:0], remainder [63:32], order [65:64]
    logic [0:0]  m_axis_tuser;        // is_negative [0]

    alu_res_t pending_results [$];
    int       op_count [8];
    int       results_seen;
    int       mismatch_count;
    bit       sender_steady;

    multiword_integer_alu_unit #(
        .WIDTH_BYTES(DEF_WIDTH_BYTES)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // expected result of one item: wrapping add, negate, compare,
    // msb-first shift-and-add product and restoring division
    function automatic alu_res_t alu_compute(input alu_req_t req);
        alu_res_t    r;
        logic [31:0] acc;
        logic [31:0] quo;
        logic [31:0] rem;
        logic        carry;
        r = '0;
        case (req.op)
            OP_ADD: r.main_result = req.a + req.b;
            OP_NEG: r.main_result = ~req.a + 32'd1;
            OP_CMP: begin
                if (req.a == req.b)
                    r.order = ORD_EQ;
                else if (req.a < req.b)
                    r.order = ORD_LT;
                else
                    r.order = ORD_GT;
            end
            OP_MUL: begin
                acc = '0;
                for (int i = 31; i >= 0; i--) begin
                    acc = acc << 1;
                    if (req.b[i])
                        acc = acc + req.a;
                end
                r.main_result = acc;
            end
            OP_DIV: begin
                quo = '0;
                rem = '0;
                // the bit shifted out of the remainder still counts
                for (int i = 31; i >= 0; i--) begin
                    carry = rem[31];
                    rem = {rem[30:0], req.a[i]};
                    if (carry || rem >= req.b) begin
                        rem = rem - req.b;
                        quo[i] = 1'b1;
                    end
                end
                r.main_result = quo;
                r.remainder = rem;
            end
            default: ;
        endcase
        r.is_negative = r.main_result[31];
        return r;
    endfunction

    // operand with a bias towards small, near-full and single-bit values
    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        case ($urandom_range(5))
            0, 1:    v = $urandom;
            2:       v = 32'($urandom_range(255));
            3:       v = 32'hffff_ffff - 32'($urandom_range(255));
            4:       v = 32'h1 << $urandom_range(31);
            default: v = {1'b1, 31'($urandom)};
        endcase
        return v;
    endfunction

    function automatic alu_req_t random_request();
        alu_req_t req;
        if ($urandom_range(99) < 8)
            req.op = 3'($urandom_range(OP_RSVD_7, OP_RSVD_5));
        else
            req.op = 3'($urandom_range(OP_DIV, OP_ADD));
        req.a = random_operand();
        req.b = random_operand();
        // equal operands for compare, and divisors that hit the corner cases
        if (req.op == OP_CMP && $urandom_range(3) == 0)
            req.b = req.a;
        if (req.op == OP_DIV) begin
            case ($urandom_range(9))
                0:       req.b = '0;
                1, 2:    req.b = 32'($urandom_range(255));
                3, 4:    req.b = {1'b1, 31'($urandom)};
                default: ;
            endcase
        end
        return req;
    endfunction

    // offer one item and wait until it is taken
    task automatic send_item(input alu_req_t req, input alu_res_t want);
        if (!sender_steady) begin
            while ($urandom_range(99) < 15) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.b, req.a};
        s_axis_tuser  <= req.op;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        pending_results.push_back(want);
        op_count[req.op]++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // receiver: random stalls, one long hold-off and a stretch with none
    initial begin
        int rx_cycle;
        int hold_left;
        rx_cycle = 0;
        hold_left = 0;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (rx_cycle == 2500)
                hold_left = 400;
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (rx_cycle >= 6000 && rx_cycle < 9000) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 15);
            end
            @(posedge aclk);
            rx_cycle++;
        end
    end

    // result checking against the oldest expectation
    always @(posedge aclk) begin
        alu_res_t want;
        alu_res_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[65:64],
                    m_axis_tuser[0]};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: main %h rem %h ord %0d neg %b",
                             $realtime, got.main_result, got.remainder, got.order,
                             got.is_negative);
            end else begin
                want = pending_results.pop_front();
                if (got.main_result !== want.main_result || got.remainder !== want.remainder ||
                    got.order !== want.order || got.is_negative !== want.is_negative) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp main %h rem %h ord %0d neg %b, got main %h rem %h ord %0d neg %b",
                                 $realtime, want.main_result, want.remainder, want.order,
                                 want.is_negative, got.main_result, got.remainder, got.order,
                                 got.is_negative);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        alu_req_t req;
        sender_steady = 1'b0;
        results_seen = 0;
        mismatch_count = 0;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].typed)
                send_item(DIRECTED[i].req, DIRECTED[i].res);
            else
                send_item(DIRECTED[i].req, alu_compute(DIRECTED[i].req));
        end

        // sender pauses until the unit has emptied
        s_axis_tvalid <= 1'b0;
        wait_drained();
        @(posedge aclk);

        // random items, with a stretch of back-to-back offering and a mid-run pause
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sender_steady = (n >= 300 && n < 600);
            if (n == 800) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                @(posedge aclk);
            end
            req = random_request();
            send_item(req, alu_compute(req));
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (50) @(posedge aclk);

        $display("items sent: add %0d, negate %0d, compare %0d, multiply %0d, divide %0d, unknown op %0d",
                 op_count[OP_ADD], op_count[OP_NEG], op_count[OP_CMP], op_count[OP_MUL],
                 op_count[OP_DIV], op_count[OP_RSVD_5] + op_count[OP_RSVD_6] +
                 op_count[OP_RSVD_7]);
        $display("results checked %0d, mismatches %0d", results_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("multiword_integer_alu_unit test passed");
        else
            $display("multiword_integer_alu_unit test failed");
        $finish;
    end

    // overall time limit
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("multiword_integer_alu_unit test failed");
        $finish;
    end

endmodule
